[hw/rtl/vdg_graphics_pixel_expander_core_defines.svh]
// Assertion macros for the checker of the graphics pixel expander.
// Depends on nothing; included by the checker file.
`ifndef VDG_GRAPHICS_PIXEL_EXPANDER_CORE_DEFINES_SVH
`define VDG_GRAPHICS_PIXEL_EXPANDER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define VDGPE_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define VDGPE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/vdgpe_pkg.sv]
// Shared types, constants and the palette of the graphics pixel expander.
// Depends on nothing; used by the front, queue, back and top modules of the block.
package vdgpe_pkg;

	localparam int unsigned LINE_PIXELS_DEF = 256;

	localparam int unsigned PIX_W   = 5;
	localparam int unsigned MAX_PIX = 16;
	localparam int unsigned IDX_W   = 4;
	localparam int unsigned ADDR_W  = 16;
	localparam int unsigned BCNT_W  = 13;
	localparam int unsigned QPTR_W  = 1;
	localparam int unsigned Q_DEPTH = 1 << QPTR_W;

	typedef logic [PIX_W-1:0] pix_t;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		CFG_SAM  = 2'd0,
		CFG_PIA  = 2'd1,
		CFG_CSS  = 2'd2,
		CFG_PAGE = 2'd3
	} cfg_reg_t;

	localparam logic [2:0] SAM_DMA  = 3'd7;
	localparam logic [2:0] SAM_HALF = 3'd4;

	localparam logic [1:0] CSS_FROM_PIA = 2'd0;
	localparam logic [1:0] CSS_SET0     = 2'd1;

	// Graphics mode codes from the PIA GM bits.
	localparam logic [2:0] GM_1C = 3'd0;
	localparam logic [2:0] GM_1R = 3'd1;
	localparam logic [2:0] GM_2C = 3'd2;
	localparam logic [2:0] GM_2R = 3'd3;
	localparam logic [2:0] GM_3C = 3'd4;
	localparam logic [2:0] GM_3R = 3'd5;
	localparam logic [2:0] GM_6C = 3'd6;
	localparam logic [2:0] GM_6R = 3'd7;

	localparam pix_t PIX_BLACK      = 5'd0;
	localparam pix_t PIX_ART_BLUE   = 5'd16;
	localparam pix_t PIX_ART_ORANGE = 5'd17;
	localparam pix_t PIX_NONE       = 5'd31;

	// One expanded byte, as handed from the front to the back.
	typedef struct packed {
		pix_t [MAX_PIX-1:0] pix;
		logic [IDX_W-1:0]   last_idx;
		logic               line_end;
		logic               frame_end;
		logic [1:0]         row_repeat;
		logic [ADDR_W-1:0]  addr;
	} job_t;

	typedef struct packed {
		logic full;
		logic not_empty;
	} q_status_t;

	function automatic pix_t palette(input logic [2:0] idx);
		pix_t c;
		case (idx)
			3'd0:    c = 5'd10;
			3'd1:    c = 5'd14;
			3'd2:    c = 5'd9;
			3'd3:    c = 5'd12;
			3'd4:    c = 5'd15;
			3'd5:    c = 5'd3;
			3'd6:    c = 5'd13;
			default: c = 5'd6;
		endcase
		return c;
	endfunction

endpackage

[hw/rtl/vdgpe_front.sv]
// Front end: configuration registers, mode decode and expansion of one byte.
// Depends on vdgpe_pkg.
module vdgpe_front #(
	parameter int unsigned LINE_PIXELS = vdgpe_pkg::LINE_PIXELS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr,
	input  logic [1:0]          cfg_index,
	input  logic [7:0]          cfg_data,
	input  logic                take,
	input  logic [7:0]          video_byte,
	output logic                push,
	output vdgpe_pkg::job_t     job
);

	localparam int unsigned FILL_W = $clog2(LINE_PIXELS);
	localparam int unsigned SUM_W  = FILL_W + 1;

	logic [2:0] sam_q;
	logic [4:0] pia_q;
	logic [1:0] css_q;
	logic [5:0] page_q;

	logic [vdgpe_pkg::BCNT_W-1:0] bcnt_q;
	logic [FILL_W-1:0]            fill_q;
	vdgpe_pkg::pix_t              prev_q;

	logic                         active;
	logic [2:0]                   gm;
	logic                         css;
	logic                         colour;
	logic                         wide;
	logic                         art;
	logic                         sixteen;
	logic [1:0]                   rowrep;
	logic [vdgpe_pkg::BCNT_W-1:0] frame_last;
	vdgpe_pkg::pix_t              fg;
	vdgpe_pkg::pix_t              c_art [8];
	vdgpe_pkg::pix_t [vdgpe_pkg::MAX_PIX-1:0] pix;
	logic [SUM_W-1:0]             sum;
	logic [SUM_W-1:0]             rem;
	logic                         line_done;
	logic                         frame_done;

	assign active = (sam_q != vdgpe_pkg::SAM_DMA) && pia_q[4];
	assign gm     = pia_q[3:1];
	assign fg     = vdgpe_pkg::palette({css, 2'b00});

	always_comb begin
		case (css_q)
			vdgpe_pkg::CSS_FROM_PIA: css = pia_q[0];
			vdgpe_pkg::CSS_SET0:     css = 1'b0;
			default:                 css = 1'b1;
		endcase
	end

	// Mode decode, including the half-height overrides of the SAM.
	always_comb begin
		colour     = 1'b0;
		wide       = 1'b0;
		art        = 1'b0;
		rowrep     = 2'd1;
		frame_last = 13'd6143;
		unique case (gm)
			vdgpe_pkg::GM_1C: begin
				colour = 1'b1; wide = 1'b1; rowrep = 2'd3; frame_last = 13'd1023;
			end
			vdgpe_pkg::GM_1R: begin
				rowrep = 2'd3; frame_last = 13'd1023;
			end
			vdgpe_pkg::GM_2C: begin
				colour = 1'b1;
				if (sam_q == vdgpe_pkg::SAM_HALF) begin
					rowrep = 2'd2; frame_last = 13'd3071;
				end else begin
					rowrep = 2'd3; frame_last = 13'd2047;
				end
			end
			vdgpe_pkg::GM_2R: begin
				rowrep = 2'd2; frame_last = 13'd1535;
			end
			vdgpe_pkg::GM_3C: begin
				colour = 1'b1; rowrep = 2'd2; frame_last = 13'd3071;
			end
			vdgpe_pkg::GM_3R: begin
				rowrep = 2'd1; frame_last = 13'd3071;
			end
			vdgpe_pkg::GM_6C: begin
				colour = 1'b1; rowrep = 2'd1; frame_last = 13'd6143;
			end
			vdgpe_pkg::GM_6R: begin
				art = 1'b1;
				if (sam_q == vdgpe_pkg::SAM_HALF) begin
					rowrep = 2'd2; frame_last = 13'd3071;
				end else begin
					rowrep = 2'd1; frame_last = 13'd6143;
				end
			end
		endcase
	end

	// Sixteen pixels for the four-colour wide mode and the doubled resolution modes.
	assign sixteen = wide || (!colour && !art);

	// Pixel expansion. Each pixel depends only on the byte and on the state at entry.
	always_comb begin
		logic [1:0]      field;
		logic            odd;
		vdgpe_pkg::pix_t prev;
		pix   = '0;
		field = '0;
		odd   = 1'b0;
		prev  = vdgpe_pkg::PIX_NONE;
		for (int j = 0; j < 8; j++) begin
			c_art[j] = video_byte[7-j] ? fg : vdgpe_pkg::PIX_BLACK;
		end
		for (int j = 0; j < 16; j++) begin
			if (colour && wide) begin
				field  = 2'(video_byte >> (6 - 2 * (j / 4)));
				pix[j] = vdgpe_pkg::palette({css, field});
			end else if (colour) begin
				field  = 2'(video_byte >> (6 - 2 * ((j % 8) / 2)));
				pix[j] = (j < 8) ? vdgpe_pkg::palette({css, field}) : vdgpe_pkg::PIX_BLACK;
			end else if (!art) begin
				pix[j] = video_byte[7 - j / 2] ? fg : vdgpe_pkg::PIX_BLACK;
			end
		end
		// Artifact colours: a pixel that differs from its left neighbour becomes blue or
		// orange, by its parity on the line. An all-zero byte is plain black.
		if (art && video_byte != 8'd0) begin
			for (int j = 0; j < 8; j++) begin
				prev = (j == 0) ? prev_q : c_art[(j + 7) % 8];
				odd  = fill_q[0] ^ 1'(j & 1);
				if (c_art[j] != prev) begin
					if (odd) begin
						pix[j] = (c_art[j] == vdgpe_pkg::PIX_BLACK) ?
							vdgpe_pkg::PIX_ART_ORANGE : vdgpe_pkg::PIX_ART_BLUE;
					end else begin
						pix[j] = (c_art[j] == vdgpe_pkg::PIX_BLACK) ?
							vdgpe_pkg::PIX_ART_BLUE : vdgpe_pkg::PIX_ART_ORANGE;
					end
				end else begin
					pix[j] = c_art[j];
				end
			end
		end
	end

	assign sum        = {1'b0, fill_q} + (sixteen ? SUM_W'(16) : SUM_W'(8));
	assign line_done  = sum >= SUM_W'(LINE_PIXELS);
	assign rem        = SUM_W'(LINE_PIXELS) - SUM_W'(1) - {1'b0, fill_q};
	assign frame_done = bcnt_q >= frame_last;

	always_comb begin
		job.pix        = pix;
		job.last_idx   = line_done ? rem[vdgpe_pkg::IDX_W-1:0] :
			(sixteen ? vdgpe_pkg::IDX_W'(15) : vdgpe_pkg::IDX_W'(7));
		job.line_end   = line_done;
		job.frame_end  = frame_done;
		job.row_repeat = rowrep;
		job.addr       = vdgpe_pkg::ADDR_W'({page_q, 9'd0}) + vdgpe_pkg::ADDR_W'(bcnt_q);
	end

	assign push = take && active;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sam_q  <= 3'd0;
			pia_q  <= 5'd0;
			css_q  <= 2'd0;
			page_q <= 6'd2;
		end else if (cfg_wr) begin
			unique case (vdgpe_pkg::cfg_reg_t'(cfg_index))
				vdgpe_pkg::CFG_SAM:  sam_q  <= cfg_data[2:0];
				vdgpe_pkg::CFG_PIA:  pia_q  <= cfg_data[4:0];
				vdgpe_pkg::CFG_CSS:  css_q  <= cfg_data[1:0];
				vdgpe_pkg::CFG_PAGE: page_q <= cfg_data[5:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bcnt_q <= '0;
			fill_q <= '0;
			prev_q <= vdgpe_pkg::PIX_NONE;
		end else if (push) begin
			if (frame_done) begin
				bcnt_q <= '0;
				fill_q <= '0;
				prev_q <= vdgpe_pkg::PIX_NONE;
			end else begin
				bcnt_q <= bcnt_q + 1'b1;
				fill_q <= line_done ? '0 : sum[FILL_W-1:0];
				if (art) begin
					prev_q <= (video_byte == 8'd0) ? vdgpe_pkg::PIX_BLACK : c_art[7];
				end
			end
		end
	end

endmodule

[hw/rtl/vdgpe_queue.sv]
// Short queue of expanded bytes between the front and the back.
// Depends on vdgpe_pkg.
module vdgpe_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  vdgpe_pkg::job_t       push_job,
	input  logic                  pop,
	output vdgpe_pkg::job_t       head,
	output vdgpe_pkg::q_status_t  status
);

	vdgpe_pkg::job_t                 mem_q [vdgpe_pkg::Q_DEPTH];
	logic [vdgpe_pkg::QPTR_W-1:0]    wr_q;
	logic [vdgpe_pkg::QPTR_W-1:0]    rd_q;
	logic [vdgpe_pkg::QPTR_W:0]      cnt_q;

	assign head             = mem_q[rd_q];
	assign status.full      = cnt_q == (vdgpe_pkg::QPTR_W + 1)'(vdgpe_pkg::Q_DEPTH);
	assign status.not_empty = cnt_q != '0;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop)  rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (vdgpe_pkg::QPTR_W + 1)'(push) - (vdgpe_pkg::QPTR_W + 1)'(pop);
		end
	end

endmodule

[hw/rtl/vdgpe_back.sv]
// Back end: puts queue-head pixels in the output register, one a cycle unless stalled.
// Depends on vdgpe_pkg.
module vdgpe_back (
	input  logic                               clk,
	input  logic                               arst_n,
	input  vdgpe_pkg::job_t                    head,
	input  vdgpe_pkg::q_status_t               status,
	output logic                               pop,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [4:0]                         pixel_color,
	output logic                               line_end,
	output logic [1:0]                         row_repeat,
	output logic                               frame_end,
	output logic                               last,
	output logic [15:0]                        byte_address
);

	logic [vdgpe_pkg::IDX_W-1:0] idx_q;
	logic                        out_valid_q;
	logic                        load;
	logic                        is_last;

	assign load      = status.not_empty && (!out_valid_q || !out_stall);
	assign is_last   = idx_q == head.last_idx;
	assign pop       = load && is_last;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (!out_valid_q || !out_stall) out_valid_q <= status.not_empty;
			if (load) idx_q <= is_last ? '0 : idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			pixel_color  <= head.pix[idx_q];
			line_end     <= is_last && head.line_end;
			frame_end    <= is_last && head.frame_end;
			last         <= is_last;
			row_repeat   <= head.row_repeat;
			byte_address <= head.addr;
		end
	end

endmodule

[hw/rtl/vdg_graphics_pixel_expander_core.sv]
// Graphics pixel expander: one display byte in, 8 or 16 palette-coded pixels out.
// A taken byte is written into the queue, then its first pixel into the output register.
// Throughput: one pixel per clock unless out_stall holds it; a byte gives 8 or 16 pixels
// (fewer at a line break), which the back end moves one a cycle into the output register.
// Reset: arst_n at once clears counters, queue and output valid; config takes defaults.
module vdg_graphics_pixel_expander_core #(
	parameter int unsigned LINE_PIXELS = vdgpe_pkg::LINE_PIXELS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  video_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [4:0]  pixel_color,
	output logic        line_end,
	output logic [1:0]  row_repeat,
	output logic        frame_end,
	output logic        last,
	output logic [15:0] byte_address
);

	// The front end decodes the mode, expands a whole byte in the cycle it is taken and
	// advances the byte counter, the line fill and the previous 6R pixel. Bytes in text,
	// semigraphics or DMA mode are taken and dropped without touching that state.
	// Expanded bytes wait in a two-entry queue, so the source may run ahead of the
	// back end by up to two bytes while a pixel waits on the output.

	vdgpe_pkg::job_t      job;
	vdgpe_pkg::job_t      head;
	vdgpe_pkg::q_status_t q_status;
	logic                 push;
	logic                 pop;
	logic                 take;

	// Configuration is always taken; users write it only while the block is idle; unchecked.
	assign cfg_ready = 1'b1;

	// A byte is refused only while the queue holds two expanded bytes.
	assign in_stall = q_status.full;
	assign take     = in_valid && !in_stall;

	vdgpe_front #(
		.LINE_PIXELS(LINE_PIXELS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.take      (take),
		.video_byte(video_byte),
		.push      (push),
		.job       (job)
	);

	vdgpe_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_job(job),
		.pop     (pop),
		.head    (head),
		.status  (q_status)
	);

	// The back end emits one pixel per cycle from the queue head unless the output stalls,
	// and frees the entry as its last pixel moves into the output register.
	vdgpe_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.status      (q_status),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.pixel_color (pixel_color),
		.line_end    (line_end),
		.row_repeat  (row_repeat),
		.frame_end   (frame_end),
		.last        (last),
		.byte_address(byte_address)
	);

endmodule

[hw/rtl/vdgpe_checker.sv]
// Port-level checks of the graphics pixel expander, bound to its top level.
// Depends on vdg_graphics_pixel_expander_core_defines.svh.
`include "vdg_graphics_pixel_expander_core_defines.svh"

module vdgpe_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [4:0]  pixel_color,
	input logic        line_end,
	input logic [1:0]  row_repeat,
	input logic        frame_end,
	input logic        last,
	input logic [15:0] byte_address
);

	`VDGPE_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(pixel_color) && $stable(byte_address) && $stable(last), "stalled pixel changed")
	`VDGPE_ASSERT_NOW(a_tags_on_last, clk, arst_n, out_valid && (line_end || frame_end), last, "line or frame end on a pixel that does not close its byte")
	`VDGPE_ASSERT_NOW(a_legal_pixel, clk, arst_n, out_valid, (pixel_color <= 5'd17) && (row_repeat != 2'd0), "pixel code or row repeat out of range")
	`VDGPE_ASSERT_NEXT(a_byte_continues, clk, arst_n, out_valid && !out_stall && !last, out_valid && $stable(byte_address), "pixels of a byte did not follow back to back")

endmodule

bind vdg_graphics_pixel_expander_core vdgpe_checker u_checker (.*);
